FILE: hw/rtl/scfb_pkg.sv
package scfb_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AngleW = 16;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned PosW   = 13;
  localparam int unsigned OffW   = 15;
  localparam int unsigned StepW  = 5;

  localparam logic [ByteW-1:0] HdrFirst   = 8'h12;
  localparam logic [ByteW-1:0] HdrSecond  = 8'h4C;
  localparam logic [ByteW-1:0] OpPing     = 8'h01;
  localparam logic [ByteW-1:0] OpRead     = 8'h02;
  localparam logic [ByteW-1:0] OpWrite    = 8'h03;
  localparam logic [ByteW-1:0] RegPosTime = 8'h2A;
  localparam logic [ByteW-1:0] RegPosNow  = 8'h38;
  localparam logic [ByteW-1:0] LenPing    = 8'h02;
  localparam logic [ByteW-1:0] LenSet     = 8'h07;
  localparam logic [ByteW-1:0] LenRead    = 8'h04;
  localparam logic [ByteW-1:0] ReadCount  = 8'h02;

  localparam logic signed [AngleW-1:0] AngleMax = 16'sd13500;
  localparam logic signed [AngleW-1:0] AngleMin = -16'sd13500;
  localparam logic [TimeW-1:0]         TimeMax  = 16'hFFFF;

  typedef enum logic [1:0] {
    CmdPing = 2'd0,
    CmdSet  = 2'd1,
    CmdRead = 2'd2,
    CmdRsvd = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    SrcConst,
    SrcId,
    SrcPosHi,
    SrcPosLo,
    SrcTimeHi,
    SrcTimeLo,
    SrcCsum
  } src_e;

  typedef enum logic [1:0] {
    SeqNext,
    SeqDispatch,
    SeqJump,
    SeqEnd
  } seq_e;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepHdr   = 5'd0;
  localparam step_t StepPing  = 5'd3;
  localparam step_t StepSet   = 5'd5;
  localparam step_t StepRead  = 5'd12;
  localparam step_t StepCsum  = 5'd16;

  typedef struct packed {
    src_e             src;
    logic [ByteW-1:0] data;
    logic             sum_en;
    seq_e             seq;
    step_t            target;
    logic             last;
  } ctrl_word_t;

  function automatic ctrl_word_t cw(input src_e src, input logic [ByteW-1:0] data,
                                    input logic sum_en, input seq_e seq,
                                    input step_t target, input logic last);
    ctrl_word_t w;
    w.src    = src;
    w.data   = data;
    w.sum_en = sum_en;
    w.seq    = seq;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // control store: header, id, dispatch to frame body, shared checksum step
  function automatic ctrl_word_t ucode_rom(input step_t pc);
    ctrl_word_t w;
    unique case (pc)
      5'd0:    w = cw(SrcConst,  HdrFirst,   1'b0, SeqNext,     StepHdr,  1'b0);
      5'd1:    w = cw(SrcConst,  HdrSecond,  1'b0, SeqNext,     StepHdr,  1'b0);
      5'd2:    w = cw(SrcId,     8'h00,      1'b1, SeqDispatch, StepHdr,  1'b0);
      5'd3:    w = cw(SrcConst,  LenPing,    1'b1, SeqNext,     StepHdr,  1'b0);
      5'd4:    w = cw(SrcConst,  OpPing,     1'b1, SeqJump,     StepCsum, 1'b0);
      5'd5:    w = cw(SrcConst,  LenSet,     1'b1, SeqNext,     StepHdr,  1'b0);
      5'd6:    w = cw(SrcConst,  OpWrite,    1'b1, SeqNext,     StepHdr,  1'b0);
      5'd7:    w = cw(SrcConst,  RegPosTime, 1'b1, SeqNext,     StepHdr,  1'b0);
      5'd8:    w = cw(SrcPosHi,  8'h00,      1'b1, SeqNext,     StepHdr,  1'b0);
      5'd9:    w = cw(SrcPosLo,  8'h00,      1'b1, SeqNext,     StepHdr,  1'b0);
      5'd10:   w = cw(SrcTimeHi, 8'h00,      1'b1, SeqNext,     StepHdr,  1'b0);
      5'd11:   w = cw(SrcTimeLo, 8'h00,      1'b1, SeqJump,     StepCsum, 1'b0);
      5'd12:   w = cw(SrcConst,  LenRead,    1'b1, SeqNext,     StepHdr,  1'b0);
      5'd13:   w = cw(SrcConst,  OpRead,     1'b1, SeqNext,     StepHdr,  1'b0);
      5'd14:   w = cw(SrcConst,  RegPosNow,  1'b1, SeqNext,     StepHdr,  1'b0);
      5'd15:   w = cw(SrcConst,  ReadCount,  1'b1, SeqJump,     StepCsum, 1'b0);
      5'd16:   w = cw(SrcCsum,   8'h00,      1'b0, SeqEnd,      StepHdr,  1'b1);
      default: w = cw(SrcCsum,   8'h00,      1'b0, SeqEnd,      StepHdr,  1'b1);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/scfb_if.sv
interface scfb_cmd_if;
  import scfb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic signed [AngleW-1:0] angle_centideg;
  logic [TimeW-1:0]         move_time_ms;

  modport source (output valid, output command, output angle_centideg,
                  output move_time_ms, input ready);
  modport sink   (input valid, input command, input angle_centideg,
                  input move_time_ms, output ready);
endinterface

interface scfb_frame_if;
  import scfb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface scfb_cfg_if;
  import scfb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/servo_command_frame_builder.sv
// servo command frame builder
// cmd_i takes one request: ping, set position and time, or read position.
// frame_o returns the frame one byte per transfer, last_byte marks the
// checksum byte. cfg_i writes the servo id at any transfer; it is always ready.
// frames: ping 6 bytes, set 11 bytes, read 8 bytes. a reserved command code
// is taken and dropped without any output.
// a request is taken only while no frame is being built; it starts the
// sequencer at the header step, and each byte passes through the output
// register before it shows on frame_o. the step rate is set by the control
// store sequencer, which issues one byte per cycle into the output register
// unless the receiver stalls. a receiver stall holds the output register and
// freezes the sequencer; the byte is held stable until its transfer.
// the set angle goes through a three-stage scaler that finishes before the
// position bytes are reached.
// reset clears the servo id to zero, drops any frame in progress and
// empties the output register.
module servo_command_frame_builder (
  input  logic         clk_i,
  input  logic         rst_ni,
  scfb_cmd_if.sink     cmd_i,
  scfb_frame_if.source frame_o,
  scfb_cfg_if.sink     cfg_i
);
  import scfb_pkg::*;

  logic             busy_q;
  step_t            pc_q;
  step_t            pc_d;
  cmd_e             kind_q;
  logic [ByteW-1:0] servo_id_q;
  logic [ByteW-1:0] csum_q;
  logic [OffW-1:0]  offset_q;
  logic [TimeW-1:0] time_q;
  logic [PosW-1:0]  position;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;

  logic                     cmd_fire;
  logic                     start;
  logic                     step_fire;
  ctrl_word_t               ctrl;
  logic [ByteW-1:0]         step_byte;
  logic signed [AngleW-1:0] clamped;
  logic signed [AngleW:0]   off_full;
  logic [TimeW-1:0]         time_d;
  logic [15:0]              pos_ext;

  assign cmd_i.ready = !busy_q;
  assign cfg_i.ready = 1'b1;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign start       = cmd_fire && (cmd_e'(cmd_i.command) != CmdRsvd);
  assign step_fire   = busy_q && (!out_valid_q || frame_o.ready);
  assign ctrl        = ucode_rom(pc_q);
  assign pos_ext     = 16'(position);

  always_comb begin
    priority if (cmd_i.angle_centideg > AngleMax) begin
      clamped = AngleMax;
    end else if (cmd_i.angle_centideg < AngleMin) begin
      clamped = AngleMin;
    end else begin
      clamped = cmd_i.angle_centideg;
    end
    off_full = {clamped[AngleW-1], clamped} + (AngleW+1)'(AngleMax);
    time_d   = (cmd_i.move_time_ms[TimeW-1 -: 2] != 2'b00) ? TimeMax
             : {cmd_i.move_time_ms[TimeW-3:0], 2'b00};
  end

  always_comb begin
    unique case (ctrl.src)
      SrcConst:  step_byte = ctrl.data;
      SrcId:     step_byte = servo_id_q;
      SrcPosHi:  step_byte = pos_ext[15:8];
      SrcPosLo:  step_byte = pos_ext[7:0];
      SrcTimeHi: step_byte = time_q[15:8];
      SrcTimeLo: step_byte = time_q[7:0];
      SrcCsum:   step_byte = ~csum_q;
      default:   step_byte = ~csum_q;
    endcase
  end

  always_comb begin
    unique case (ctrl.seq)
      SeqNext: pc_d = pc_q + step_t'(1);
      SeqJump: pc_d = ctrl.target;
      SeqDispatch: begin
        unique case (kind_q)
          CmdPing: pc_d = StepPing;
          CmdSet:  pc_d = StepSet;
          default: pc_d = StepRead;
        endcase
      end
      SeqEnd:  pc_d = pc_q;
      default: pc_d = pc_q;
    endcase
  end

  scfb_pos_scale u_pos_scale (
    .clk_i      (clk_i),
    .offset_i   (offset_q),
    .position_o (position)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= StepHdr;
      kind_q      <= CmdPing;
      csum_q      <= '0;
      servo_id_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        servo_id_q <= cfg_i.data;
      end
      if (start) begin
        busy_q <= 1'b1;
        pc_q   <= StepHdr;
        kind_q <= cmd_e'(cmd_i.command);
        csum_q <= '0;
      end else if (step_fire) begin
        pc_q <= pc_d;
        if (ctrl.sum_en) begin
          csum_q <= csum_q + step_byte;
        end
        if (ctrl.seq == SeqEnd) begin
          busy_q <= 1'b0;
        end
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && (cmd_e'(cmd_i.command) == CmdSet)) begin
      offset_q <= off_full[OffW-1:0];
      time_q   <= time_d;
    end
    if (step_fire) begin
      out_byte_q <= step_byte;
      out_last_q <= ctrl.last;
    end
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.last_byte  = out_last_q;

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q && busy_q) |-> (pc_q == StepHdr))
    else $error("next frame started while checksum byte still waiting");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (busy_q && pc_q == StepHdr))
    else $error("request taken but sequencer not started at header");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= StepCsum))
    else $error("sequencer ran past the control store");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_valid_q && !frame_o.ready) |=> ($stable(pc_q) && $stable(csum_q)))
    else $error("sequencer advanced during receiver stall");

endmodule

FILE: hw/rtl/scfb_pos_scale.sv
module scfb_pos_scale (
  input  logic                         clk_i,
  input  logic [scfb_pkg::OffW-1:0]    offset_i,
  output logic [scfb_pkg::PosW-1:0]    position_o
);
  import scfb_pkg::*;

  // position = offset * 512 / 3375 via reciprocal and one correction step
  localparam int unsigned NumW    = OffW + 9;
  localparam int unsigned RecipW  = 21;
  localparam int unsigned ShiftK  = 32;
  localparam int unsigned ProdW   = NumW + RecipW;
  localparam int unsigned DivW    = 12;
  localparam int unsigned BackW   = PosW + DivW;
  localparam logic [RecipW-1:0] Recip   = 21'd1272582;
  localparam logic [DivW-1:0]   Divisor = 12'd3375;

  logic [NumW-1:0]  num;
  logic [ProdW-1:0] prod_q;
  logic [NumW-1:0]  num1_q;
  logic [NumW-1:0]  num2_q;
  logic [PosW-1:0]  qest_q;
  logic [BackW-1:0] back;
  logic [BackW-1:0] rem;
  logic [PosW-1:0]  pos_d;
  logic [PosW-1:0]  pos_q;

  assign num = {offset_i, 9'd0};

  always_comb begin
    back  = BackW'(qest_q) * BackW'(Divisor);
    rem   = BackW'(num2_q) - back;
    pos_d = (rem >= BackW'(Divisor)) ? qest_q + PosW'(1) : qest_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(num) * ProdW'(Recip);
    num1_q <= num;
    qest_q <= prod_q[ShiftK +: PosW];
    num2_q <= num1_q;
    pos_q  <= pos_d;
  end

  assign position_o = pos_q;

endmodule
